// ===== sv/acr_pkg.sv =====
package acr_pkg;

    localparam logic [1:0] OP_TICK   = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_PACKET = 2'd2;

    localparam logic [15:0] OPC_REQUEST = 16'd1;
    localparam logic [15:0] OPC_REPLY   = 16'd2;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_LOOKUP = 2'd1;
    localparam logic [1:0] KIND_REPLY  = 2'd2;

    localparam logic CFG_OWN_IP   = 1'b0;
    localparam logic CFG_LIFETIME = 1'b1;

    localparam logic [31:0] LIFETIME_RESET = 32'd1000;

    // one cache line as kept in the entry ram
    typedef struct packed {
        logic [31:0] ip;
        logic [47:0] mac;
        logic [31:0] stamp;
    } t_entry;

    // what the scan engine is asked to do
    typedef struct packed {
        logic [31:0] key_ip;
        logic [47:0] mac;
        logic        learn;
    } t_job;

    typedef struct packed {
        logic        hit;
        logic [47:0] mac;
    } t_res;

endpackage

// ===== sv/acr_ram.sv =====
module acr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic                                 i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/acr_engine.sv =====
module acr_engine import acr_pkg::*; #(
    parameter int CACHE_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  t_job        i_job,
    input  logic [31:0] i_time,
    input  logic [31:0] i_lifetime,
    input  logic        i_out_free,
    output logic        o_busy,
    output logic        o_done,
    output t_res        o_res
);

    localparam int IW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(CACHE_ENTRIES - 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_LAST = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]         r_state, n_state;
    logic [IW-1:0]      r_idx;
    logic               r_p_vld;
    logic [IW-1:0]      r_p_idx;
    logic [CACHE_ENTRIES-1:0] r_valid;
    logic               r_found;
    logic [47:0]        r_fmac;
    logic               r_free_found;
    logic [IW-1:0]      r_free_idx;
    t_job               r_job;

    t_entry             rd_entry;
    t_entry             wr_entry;
    logic [$bits(t_entry)-1:0] rd_word;
    logic               ram_re;
    logic               ram_we;
    logic               key_ok;
    logic               cur_valid;
    logic               cur_aged;
    logic               cur_match;
    logic [31:0]        age;

    assign ram_re = (r_state == ST_SCAN);
    assign rd_entry = t_entry'(rd_word);
    assign key_ok = (r_job.key_ip[31:24] != 8'd0);

    assign cur_valid = r_valid[r_p_idx];
    assign age = i_time - rd_entry.stamp;
    assign cur_aged = cur_valid && (age > i_lifetime);
    assign cur_match = cur_valid && !cur_aged && key_ok && (rd_entry.ip == r_job.key_ip);

    // learning only happens once the whole table has been aged and searched
    assign ram_we = (r_state == ST_DONE) && i_out_free && r_job.learn && key_ok
                    && !r_found && r_free_found;
    assign wr_entry = '{ip: r_job.key_ip, mac: r_job.mac, stamp: i_time};

    acr_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (CACHE_ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_free_idx),
        .i_wdata (wr_entry),
        .i_re    (ram_re),
        .i_raddr (r_idx),
        .o_rdata (rd_word)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_start) n_state = ST_SCAN;
            ST_SCAN: if (r_idx == LAST_IDX) n_state = ST_LAST;
            ST_LAST: n_state = ST_DONE;
            ST_DONE: if (i_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_p_vld <= 1'b0;
            r_valid <= '0;
        end else begin
            r_state <= n_state;
            r_p_vld <= (r_state == ST_SCAN);
            if (r_p_vld && cur_aged) begin
                r_valid[r_p_idx] <= 1'b0;
            end
            if (ram_we) begin
                r_valid[r_free_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE && i_start) begin
            r_job        <= i_job;
            r_idx        <= '0;
            r_found      <= 1'b0;
            r_fmac       <= '0;
            r_free_found <= 1'b0;
            r_free_idx   <= '0;
        end else begin
            if (r_state == ST_SCAN) begin
                r_idx <= r_idx + IW'(1);
            end
            r_p_idx <= r_idx;
            if (r_p_vld) begin
                if (cur_match && !r_found) begin
                    r_found <= 1'b1;
                    r_fmac  <= rd_entry.mac;
                end
                // an entry aged out in this pass counts as free
                if ((!cur_valid || cur_aged) && !r_free_found) begin
                    r_free_found <= 1'b1;
                    r_free_idx   <= r_p_idx;
                end
            end
        end
    end

    assign o_busy = (r_state != ST_IDLE);
    assign o_done = (r_state == ST_DONE) && i_out_free;
    assign o_res  = '{hit: r_found, mac: r_fmac};

    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == ST_IDLE))
        else $error("scan started while engine busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (r_state == ST_IDLE))
        else $error("engine did not return to idle after done");

    a_write_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !r_valid[r_free_idx])
        else $error("learn overwrote a live entry");

    a_write_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> !ram_re)
        else $error("entry write overlaps table read");

endmodule

// ===== sv/arp_cache_responder.sv =====
// channel   direction  handshake                  payload
// request   in         i_in_valid / o_in_stall    i_operation .. i_frame_src_mac
// result    out        o_out_valid / i_out_stall  o_kind .. o_reply_target_ip
// config    in         i_cfg_we                   i_cfg_idx, i_cfg_data
//
// lookups and arp replies scan the whole entry table: the
// scan reads one entry per cycle from the entry ram, ages and searches it in the
// cycle after, then the done state, once the output register is free, learns the sender and loads the result.
// ticks, arp requests and ignored packets bypass the scan.
// synchronous active-low reset clears the valid bits at once; no clearing pass.
// a request is taken while a result waits in the output register; the result of
// that request waits until the output register is free.
module arp_cache_responder import acr_pkg::*; #(
    parameter int CACHE_ENTRIES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_operation,
    input  logic [31:0] i_query_ip,
    input  logic [15:0] i_packet_opcode,
    input  logic [31:0] i_sender_ip,
    input  logic [47:0] i_sender_mac,
    input  logic [31:0] i_target_ip,
    input  logic [47:0] i_frame_src_mac,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic        o_hit,
    output logic [47:0] o_found_mac,
    output logic [47:0] o_reply_frame_dest_mac,
    output logic [47:0] o_reply_target_mac,
    output logic [31:0] o_reply_target_ip
);

    logic [31:0] r_own_ip;
    logic [31:0] r_lifetime;
    logic [31:0] r_time;

    logic        r_pend;
    logic [1:0]  r_p_kind;
    logic [47:0] r_p_fdst;
    logic [47:0] r_p_tmac;
    logic [31:0] r_p_tip;
    logic        r_learn;

    logic        r_out_valid;
    logic [1:0]  r_kind;
    logic        r_hit;
    logic [47:0] r_found_mac;
    logic [47:0] r_fdst;
    logic [47:0] r_tmac;
    logic [31:0] r_tip;

    logic        in_acc;
    logic        out_free;
    logic        pkt_ok;
    logic        start;
    t_job        job;
    logic        pend_set;
    logic [1:0]  n_p_kind;
    logic        eng_busy;
    logic        eng_done;
    t_res        eng_res;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign pkt_ok   = (r_own_ip != 32'd0) && (i_target_ip == r_own_ip);

    always_comb begin
        start    = 1'b0;
        job      = '{key_ip: i_query_ip, mac: i_sender_mac, learn: 1'b0};
        pend_set = 1'b0;
        n_p_kind = KIND_NONE;
        if (in_acc) begin
            unique case (i_operation)
                OP_LOOKUP: start = 1'b1;
                OP_PACKET: begin
                    if (pkt_ok && i_packet_opcode == OPC_REPLY) begin
                        start      = 1'b1;
                        job.key_ip = i_sender_ip;
                        job.learn  = 1'b1;
                    end else begin
                        pend_set = 1'b1;
                        if (pkt_ok && i_packet_opcode == OPC_REQUEST) begin
                            n_p_kind = KIND_REPLY;
                        end
                    end
                end
                default: pend_set = 1'b1;
            endcase
        end
    end

    acr_engine #(
        .CACHE_ENTRIES (CACHE_ENTRIES)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_job      (job),
        .i_time     (r_time),
        .i_lifetime (r_lifetime),
        .i_out_free (out_free),
        .o_busy     (eng_busy),
        .o_done     (eng_done),
        .o_res      (eng_res)
    );

    assign o_in_stall = eng_busy || r_pend;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_own_ip    <= '0;
            r_lifetime  <= LIFETIME_RESET;
            r_time      <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_OWN_IP:   r_own_ip   <= i_cfg_data;
                    CFG_LIFETIME: r_lifetime <= i_cfg_data;
                    default:      r_own_ip   <= r_own_ip;
                endcase
            end
            if (in_acc && i_operation == OP_TICK) begin
                r_time <= r_time + 32'd1;
            end
            if (pend_set) begin
                r_pend <= 1'b1;
            end else if (r_pend && out_free) begin
                r_pend <= 1'b0;
            end
            if (eng_done || (r_pend && out_free)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_learn <= job.learn;
        end
        if (pend_set) begin
            r_p_kind <= n_p_kind;
            r_p_fdst <= i_frame_src_mac;
            r_p_tmac <= i_sender_mac;
            r_p_tip  <= i_sender_ip;
        end
        if (eng_done) begin
            // a learning reply reports nothing
            r_kind      <= r_learn ? KIND_NONE : KIND_LOOKUP;
            r_hit       <= eng_res.hit && !r_learn;
            r_found_mac <= r_learn ? 48'd0 : eng_res.mac;
            r_fdst      <= '0;
            r_tmac      <= '0;
            r_tip       <= '0;
        end else if (r_pend && out_free) begin
            r_kind      <= r_p_kind;
            r_hit       <= 1'b0;
            r_found_mac <= '0;
            // reply fields stay zero unless a reply is sent
            r_fdst      <= (r_p_kind == KIND_REPLY) ? r_p_fdst : 48'd0;
            r_tmac      <= (r_p_kind == KIND_REPLY) ? r_p_tmac : 48'd0;
            r_tip       <= (r_p_kind == KIND_REPLY) ? r_p_tip  : 32'd0;
        end
    end

    assign o_out_valid            = r_out_valid;
    assign o_kind                 = r_kind;
    assign o_hit                  = r_hit;
    assign o_found_mac            = r_found_mac;
    assign o_reply_frame_dest_mac = r_fdst;
    assign o_reply_target_mac     = r_tmac;
    assign o_reply_target_ip      = r_tip;

endmodule
